// File: rtl/sntf_pkg.sv
// Shared constants, register codes and the semitone ratio table for the note-to-frequency block.
package sntf_pkg;

	localparam int MASK_W    = 12;
	localparam int BASE_W    = 32;
	localparam int FREQ_W    = 48;
	localparam int STEPS_W   = 12;
	localparam int COUNT_W   = 4;
	localparam int ENTRY_W   = 4;
	localparam int ROM_W     = 33;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_TONE_MASK      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BASE_FREQUENCY = 2'd1;

	localparam logic [MASK_W-1:0] TONE_MASK_RESET = 12'd1193;
	localparam logic [BASE_W-1:0] BASE_RESET      = 32'd28835840;
	localparam logic [FREQ_W-1:0] FREQ_MAX        = '1;

	// 2^(m/12) in Q1.32, rounded to nearest.
	function automatic logic [ROM_W-1:0] ratio_rom32(input logic [ENTRY_W-1:0] m);
		logic [ROM_W-1:0] v;
		case (m)
			4'd0:    v = 33'd4294967296;
			4'd1:    v = 33'd4550359342;
			4'd2:    v = 33'd4820937788;
			4'd3:    v = 33'd5107605667;
			4'd4:    v = 33'd5411319705;
			4'd5:    v = 33'd5733093519;
			4'd6:    v = 33'd6074001001;
			4'd7:    v = 33'd6435179895;
			4'd8:    v = 33'd6817835604;
			4'd9:    v = 33'd7223245206;
			4'd10:   v = 33'd7652761717;
			4'd11:   v = 33'd8107818609;
			default: v = 33'd4294967296;
		endcase
		return v;
	endfunction

	// Ratio rounded half up to frac_bits fraction bits.
	function automatic logic [ROM_W-1:0] ratio_round(input logic [ENTRY_W-1:0] m,
			input int unsigned frac_bits);
		logic [ROM_W-1:0] v;
		int unsigned sh;
		v  = ratio_rom32(m);
		sh = 32 - frac_bits;
		if (sh == 0) begin
			return v;
		end
		return (v + (ROM_W'(1) << (sh - 1))) >> sh;
	endfunction

	function automatic logic [COUNT_W-1:0] popcount12(input logic [MASK_W-1:0] mask);
		logic [COUNT_W-1:0] c;
		c = '0;
		for (int k = 0; k < MASK_W; k++) begin
			c = c + COUNT_W'(mask[k]);
		end
		return c;
	endfunction

endpackage

// File: rtl/sntf_if.sv
// Handshake channels of the note-to-frequency block: notes in, results out, register writes.
interface sntf_note_if #(parameter int NOTE_W = 8);
	logic              valid;
	logic              ready;
	logic [NOTE_W-1:0] note_number;

	modport source (output valid, output note_number, input ready);
	modport sink   (input valid, input note_number, output ready);
endinterface

interface sntf_freq_if;
	logic                           valid;
	logic                           ready;
	logic [sntf_pkg::FREQ_W-1:0]    frequency;
	logic                           saturated;
	logic [sntf_pkg::STEPS_W-1:0]   halfsteps;

	modport source (output valid, output frequency, output saturated, output halfsteps,
		input ready);
	modport sink   (input valid, input frequency, input saturated, input halfsteps,
		output ready);
endinterface

interface sntf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sntf_pkg::REG_IDX_W-1:0]  index;
	logic [sntf_pkg::BASE_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sntf_div.sv
// Pipelined restoring divider: splits the note into octave (quotient) and scale index (remainder).
module sntf_div #(
	parameter int NOTE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NOTE_BITS-1:0]          note,
	input  logic [sntf_pkg::COUNT_W-1:0]  count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [NOTE_BITS-1:0]          quotient,
	output logic [sntf_pkg::COUNT_W-1:0]  remainder
);
	import sntf_pkg::*;

	localparam int DB  = 4;
	localparam int NS  = (NOTE_BITS + DB - 1) / DB;
	localparam int NPW = NS * DB;

	logic [NPW-1:0]     dq_s  [NS];
	logic [COUNT_W-1:0] rem_s [NS];
	logic [NS-1:0]      valid_s;
	logic [NS-1:0]      adv;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [NPW-1:0]     dq_i;
		logic [NPW-1:0]     dq_o;
		logic [COUNT_W-1:0] rem_i;
		logic [COUNT_W-1:0] rem_o;
		logic               v_i;
		logic               nxt_adv;

		if (k == 0) begin : g_first
			assign dq_i  = NPW'(note);
			assign rem_i = '0;
			assign v_i   = in_valid;
		end else begin : g_next
			assign dq_i  = dq_s[k-1];
			assign rem_i = rem_s[k-1];
			assign v_i   = valid_s[k-1];
		end

		if (k == NS - 1) begin : g_last
			assign nxt_adv = out_ready;
		end else begin : g_mid
			assign nxt_adv = adv[k+1];
		end

		assign adv[k] = !valid_s[k] || nxt_adv;

		// The dividend shifts out at the top while quotient bits enter at the bottom.
		always_comb begin
			logic [COUNT_W:0] trial;
			dq_o  = dq_i;
			rem_o = rem_i;
			for (int j = 0; j < DB; j++) begin
				trial = {rem_o, dq_o[NPW-1]};
				dq_o  = {dq_o[NPW-2:0], 1'b0};
				if (trial >= {1'b0, count}) begin
					trial   = trial - {1'b0, count};
					dq_o[0] = 1'b1;
				end
				rem_o = trial[COUNT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv[k]) begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				dq_s[k]  <= dq_o;
				rem_s[k] <= rem_o;
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[NS-1];
	assign quotient  = dq_s[NS-1][NOTE_BITS-1:0];
	assign remainder = rem_s[NS-1];

endmodule

// File: rtl/sntf_mul.sv
// Scale map lookup, ratio table and the two-step product of base frequency and ratio.
module sntf_mul #(
	parameter int NOTE_BITS           = 8,
	parameter int RATIO_FRACTION_BITS = 24,
	parameter int PW                  = 32 + RATIO_FRACTION_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NOTE_BITS-1:0]          octave,
	input  logic [sntf_pkg::COUNT_W-1:0]  remainder,
	input  logic [sntf_pkg::MASK_W-1:0]   tone_mask,
	input  logic [sntf_pkg::BASE_W-1:0]   base_frequency,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [PW-1:0]                 product,
	output logic [NOTE_BITS-1:0]          octave_out,
	output logic [sntf_pkg::STEPS_W-1:0]  halfsteps
);
	import sntf_pkg::*;

	localparam int RW  = RATIO_FRACTION_BITS + 1;
	localparam int LW  = RW / 2;
	localparam int HW  = RW - LW;

	logic [ENTRY_W-1:0]   entry;
	logic [ROM_W-1:0]     ratio_full;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 adv1, adv2, adv3;
	logic [ENTRY_W-1:0]   entry_s1;
	logic [RW-1:0]        ratio_s1;
	logic [NOTE_BITS-1:0] oct_s1, oct_s2, oct_s3;
	logic [BASE_W+HW-1:0] pp_hi_s2;
	logic [BASE_W+LW-1:0] pp_lo_s2;
	logic [STEPS_W-1:0]   steps_s2, steps_s3;
	logic [PW-1:0]        prod_s3;

	// The map entry is the semitone whose set bit has exactly 'remainder' set bits below it.
	always_comb begin
		logic [COUNT_W-1:0] below;
		entry = '0;
		for (int k = 0; k < MASK_W; k++) begin
			below = '0;
			for (int b = 0; b < k; b++) begin
				below = below + COUNT_W'(tone_mask[b]);
			end
			if (tone_mask[k] && below == remainder) begin
				entry = ENTRY_W'(k);
			end
		end
	end

	assign ratio_full = ratio_round(entry, RATIO_FRACTION_BITS);

	assign adv3 = !valid_s3 || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			entry_s1 <= entry;
			ratio_s1 <= ratio_full[RW-1:0];
			oct_s1   <= octave;
		end
		if (adv2) begin
			pp_hi_s2 <= base_frequency * ratio_s1[RW-1:LW];
			pp_lo_s2 <= base_frequency * ratio_s1[LW-1:0];
			oct_s2   <= oct_s1;
			steps_s2 <= STEPS_W'({oct_s1, 3'b000}) + STEPS_W'({oct_s1, 2'b00})
				+ STEPS_W'(entry_s1);
		end
		if (adv3) begin
			prod_s3  <= (PW'(pp_hi_s2) << LW) + PW'(pp_lo_s2);
			oct_s3   <= oct_s2;
			steps_s3 <= steps_s2;
		end
	end

	assign in_ready   = adv1;
	assign out_valid  = valid_s3;
	assign product    = prod_s3;
	assign octave_out = oct_s3;
	assign halfsteps  = steps_s3;

endmodule

// File: rtl/sntf_shift.sv
// Octave shift with round-half-up, saturation to 48 bits, and the output register.
module sntf_shift #(
	parameter int NOTE_BITS           = 8,
	parameter int RATIO_FRACTION_BITS = 24,
	parameter int PW                  = 32 + RATIO_FRACTION_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PW-1:0]                 product,
	input  logic [NOTE_BITS-1:0]          octave,
	input  logic [sntf_pkg::STEPS_W-1:0]  halfsteps_in,
	input  logic                          empty,
	input  logic [sntf_pkg::BASE_W-1:0]   base_frequency,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sntf_pkg::FREQ_W-1:0]   frequency,
	output logic                          saturated,
	output logic [sntf_pkg::STEPS_W-1:0]  halfsteps
);
	import sntf_pkg::*;

	localparam int CW = (NOTE_BITS > 6 ? NOTE_BITS : 6) + 1;
	localparam int VW = (PW + 1 > FREQ_W + 1) ? PW + 1 : FREQ_W + 1;
	localparam logic [CW-1:0] RFB_C = CW'(RATIO_FRACTION_BITS);
	localparam logic [CW-1:0] SHIFT_LIMIT = CW'(FREQ_W);

	logic [CW-1:0]      oct_c, lsh_full, rsh_full;
	logic [5:0]         lsh, rsh;
	logic               go_left, too_far;
	logic [VW-1:0]      p_ext, shl, pa, shr;
	logic [FREQ_W-1:0]  cap;
	logic               ovf;
	logic [FREQ_W-1:0]  value;
	logic [FREQ_W-1:0]  freq_nx;
	logic               sat_nx;

	logic               valid_s1, adv;
	logic [FREQ_W-1:0]  freq_s1;
	logic               sat_s1;
	logic [STEPS_W-1:0] steps_s1;

	assign oct_c    = CW'(octave);
	assign go_left  = oct_c >= RFB_C;
	assign lsh_full = oct_c - RFB_C;
	assign rsh_full = RFB_C - oct_c;
	assign too_far  = lsh_full >= SHIFT_LIMIT;
	assign lsh      = lsh_full[5:0];
	assign rsh      = rsh_full[5:0];
	assign p_ext    = VW'(product);
	assign cap      = FREQ_MAX >> lsh;
	assign shl      = p_ext << lsh;
	assign pa       = p_ext + (VW'(1) << (rsh - 6'd1));
	assign shr      = pa >> rsh;

	always_comb begin
		if (go_left) begin
			// A zero product never overflows, however far it is shifted.
			ovf   = (product != '0) && (too_far || p_ext > VW'(cap));
			value = shl[FREQ_W-1:0];
		end else begin
			ovf   = |shr[VW-1:FREQ_W];
			value = shr[FREQ_W-1:0];
		end
		if (empty) begin
			freq_nx = FREQ_W'(base_frequency);
			sat_nx  = 1'b0;
		end else if (ovf) begin
			freq_nx = FREQ_MAX;
			sat_nx  = 1'b1;
		end else begin
			freq_nx = value;
			sat_nx  = 1'b0;
		end
	end

	assign adv = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			freq_s1  <= freq_nx;
			sat_s1   <= sat_nx;
			steps_s1 <= empty ? '0 : halfsteps_in;
		end
	end

	assign in_ready  = adv;
	assign out_valid = valid_s1;
	assign frequency = freq_s1;
	assign saturated = sat_s1;
	assign halfsteps = steps_s1;

endmodule

// File: rtl/scale_note_to_frequency.sv
// Top level of the scale-note-to-frequency pipeline with its configuration registers.
//
//   Port   Role    Carries
//   note   sink    note_number (NOTE_BITS bits)
//   result source  frequency (Q32.16), saturated, halfsteps
//   cfg    sink    index, data: 0 = tone_mask, 1 = base_frequency
//
// One note is taken per cycle while the pipeline is not full and stalled. The stages are
// divider stages of four quotient bits each, map and ratio lookup, the split 32-bit multiply,
// the sum of partial products, and the shift and saturate stage that is also the output register.
// Reset clears the valid bits and loads the minor pentatonic mask and 440 Hz.
// Each stage holds while its successor is full and stalled, so bubbles still fill.
module scale_note_to_frequency #(
	parameter int NOTE_BITS           = 8,
	parameter int RATIO_FRACTION_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	sntf_note_if.sink    note,
	sntf_freq_if.source  result,
	sntf_cfg_if.sink     cfg
);
	import sntf_pkg::*;

	localparam int PW = 32 + RATIO_FRACTION_BITS + 1;

	logic [MASK_W-1:0]    tone_mask_q;
	logic [BASE_W-1:0]    base_frequency_q;
	logic [COUNT_W-1:0]   count;
	logic                 empty;

	logic                 div_valid, div_ready;
	logic [NOTE_BITS-1:0] div_quotient;
	logic [COUNT_W-1:0]   div_remainder;

	logic                 mul_valid, mul_ready;
	logic [PW-1:0]        mul_product;
	logic [NOTE_BITS-1:0] mul_octave;
	logic [STEPS_W-1:0]   mul_halfsteps;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_mask_q      <= TONE_MASK_RESET;
			base_frequency_q <= BASE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TONE_MASK:      tone_mask_q      <= cfg.data[MASK_W-1:0];
				REG_BASE_FREQUENCY: base_frequency_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign count = popcount12(tone_mask_q);
	assign empty = (tone_mask_q == '0);

	sntf_div #(
		.NOTE_BITS (NOTE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (note.valid),
		.in_ready  (note.ready),
		.note      (NOTE_BITS'(note.note_number)),
		.count     (count),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	sntf_mul #(
		.NOTE_BITS           (NOTE_BITS),
		.RATIO_FRACTION_BITS (RATIO_FRACTION_BITS),
		.PW                  (PW)
	) u_mul (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (div_valid),
		.in_ready       (div_ready),
		.octave         (div_quotient),
		.remainder      (div_remainder),
		.tone_mask      (tone_mask_q),
		.base_frequency (base_frequency_q),
		.out_valid      (mul_valid),
		.out_ready      (mul_ready),
		.product        (mul_product),
		.octave_out     (mul_octave),
		.halfsteps      (mul_halfsteps)
	);

	sntf_shift #(
		.NOTE_BITS           (NOTE_BITS),
		.RATIO_FRACTION_BITS (RATIO_FRACTION_BITS),
		.PW                  (PW)
	) u_shift (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (mul_valid),
		.in_ready       (mul_ready),
		.product        (mul_product),
		.octave         (mul_octave),
		.halfsteps_in   (mul_halfsteps),
		.empty          (empty),
		.base_frequency (base_frequency_q),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.frequency      (result.frequency),
		.saturated      (result.saturated),
		.halfsteps      (result.halfsteps)
	);

	// A clamped result always reads as full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |-> result.frequency == FREQ_MAX)
	else $error("saturated result is not full scale");

	// An empty scale passes the base frequency through unscaled.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && empty |->
			result.frequency == FREQ_W'(base_frequency_q) && !result.saturated
			&& result.halfsteps == '0)
	else $error("empty scale did not return the base frequency");

endmodule
